// ===== rtl/bhq_pkg.sv =====
// Shared types and constants for the binary min-heap priority queue.
// Used by binary_min_heap_priority_queue and its testbench; depends on nothing.
package bhq_pkg;

   localparam int CAPACITY  = 128;
   localparam int KEY_BITS  = 32;
   localparam int SLOT_BITS = 7;
   localparam int IDX_BITS  = $clog2(CAPACITY);
   localparam int CNT_BITS  = $clog2(CAPACITY + 1);

   typedef enum logic [1:0] {
      OP_INSERT  = 2'd0,
      OP_EXTRACT = 2'd1,
      OP_REPLACE = 2'd2,
      OP_DELETE  = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_EMPTY = 2'd1,
      ST_FULL  = 2'd2,
      ST_RANGE = 2'd3
   } status_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_ROOT_RD,
      S_LAST_RD,
      S_LAST_CAP,
      S_UP_RD,
      S_UP_CMP,
      S_DN_RDL,
      S_DN_RDR,
      S_DN_CMP,
      S_DONE
   } state_type;

   typedef struct packed {
      logic [1:0]                 operation;
      logic signed [KEY_BITS-1:0] key_in;
      logic [SLOT_BITS-1:0]       slot;
   } req_type;

   typedef struct packed {
      logic signed [KEY_BITS-1:0] key_out;
      logic [1:0]                 status;
      logic [CNT_BITS-1:0]        count;
   } rsp_type;

endpackage

// ===== rtl/bhq_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// Stand-alone; depends on nothing.
module bhq_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 128
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

// ===== rtl/binary_min_heap_priority_queue.sv =====
// Binary min-heap priority queue of signed keys, held in one RAM (bhq_ram).
// One word is worked on at a time: an error goes straight to the response, and other words
// pass through setup and finish plus a read-compare step per level climbed and per level
// descended; the longest is a replace at the root that sinks seven levels.
// A response waiting in its register holds off the next word. Reset clears the count and
// control state; the heap RAM is not cleared, since only entries below the count are read.
module binary_min_heap_priority_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  bhq_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output bhq_pkg::rsp_type rsp_data
);

   localparam int KB = bhq_pkg::KEY_BITS;
   localparam int IB = bhq_pkg::IDX_BITS;
   localparam int CB = bhq_pkg::CNT_BITS;
   localparam logic [CB-1:0] CNT_ONE = CB'(1);

   bhq_pkg::state_type state_ff, state_in;
   logic [1:0]          op_ff, op_in;
   logic                moved_ff, moved_in;
   logic                down_ff, down_in;
   logic                best_left_ff, best_left_in;
   logic                have_r_ff, have_r_in;
   logic signed [KB-1:0] key_ff, key_in;
   logic signed [KB-1:0] best_ff, best_in;
   logic signed [KB-1:0] key_out_ff, key_out_in;
   logic [IB-1:0]       idx_ff, idx_in;
   logic [1:0]          status_ff, status_in;
   logic [CB-1:0]       count_ff, count_in;
   logic                rsp_valid_ff, rsp_valid_in;
   bhq_pkg::rsp_type    rsp_ff, rsp_in;

   logic                wr_en;
   logic [IB-1:0]       wr_addr;
   logic [KB-1:0]       wr_data;
   logic                rd_en;
   logic [IB-1:0]       rd_addr;
   logic [KB-1:0]       rd_raw;
   logic signed [KB-1:0] rd_key;

   logic [IB:0]         left_idx;
   logic [IB:0]         right_idx;
   logic [IB-1:0]       parent_idx;
   logic                accept;
   logic                rsp_free;

   bhq_ram #(
      .WIDTH (KB),
      .DEPTH (bhq_pkg::CAPACITY)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_raw)
   );

   assign rd_key     = $signed(rd_raw);
   assign left_idx   = {idx_ff, 1'b1};
   assign right_idx  = {idx_ff, 1'b0} + {{IB{1'b0}}, 1'b1} + {{IB{1'b0}}, 1'b1};
   assign parent_idx = (idx_ff - {{(IB-1){1'b0}}, 1'b1}) >> 1;
   assign req_ready  = (state_ff == bhq_pkg::S_IDLE) && !reset;
   assign accept     = req_valid && req_ready;
   assign rsp_free   = !rsp_valid_ff || rsp_ready;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_data   = rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= bhq_pkg::S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      op_ff        <= op_in;
      moved_ff     <= moved_in;
      down_ff      <= down_in;
      best_left_ff <= best_left_in;
      have_r_ff    <= have_r_in;
      key_ff       <= key_in;
      best_ff      <= best_in;
      key_out_ff   <= key_out_in;
      idx_ff       <= idx_in;
      status_ff    <= status_in;
      rsp_ff       <= rsp_in;
   end

   // The moving key stays in key_ff while the hole walks through the heap; each
   // step writes the displaced parent or child into the hole, and the key lands last.
   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      moved_in     = moved_ff;
      down_in      = down_ff;
      best_left_in = best_left_ff;
      have_r_in    = have_r_ff;
      key_in       = key_ff;
      best_in      = best_ff;
      key_out_in   = key_out_ff;
      idx_in       = idx_ff;
      status_in    = status_ff;
      count_in     = count_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_in       = rsp_ff;
      wr_en        = 1'b0;
      wr_addr      = idx_ff;
      wr_data      = key_ff;
      rd_en        = 1'b0;
      rd_addr      = idx_ff;

      case (state_ff)
         bhq_pkg::S_IDLE: begin
            if (accept) begin
               op_in      = req_data.operation;
               key_in     = req_data.key_in;
               key_out_in = '0;
               status_in  = bhq_pkg::ST_OK;
               moved_in   = 1'b0;
               down_in    = 1'b0;
               state_in   = bhq_pkg::S_DONE;
               case (req_data.operation)
                  bhq_pkg::OP_INSERT: begin
                     if (count_ff == CB'(bhq_pkg::CAPACITY)) begin
                        status_in = bhq_pkg::ST_FULL;
                     end else begin
                        idx_in   = count_ff[IB-1:0];
                        count_in = count_ff + CNT_ONE;
                        state_in = bhq_pkg::S_UP_RD;
                     end
                  end
                  bhq_pkg::OP_EXTRACT: begin
                     if (count_ff == '0) begin
                        status_in = bhq_pkg::ST_EMPTY;
                     end else begin
                        idx_in   = '0;
                        count_in = count_ff - CNT_ONE;
                        state_in = bhq_pkg::S_ROOT_RD;
                     end
                  end
                  default: begin
                     if (CB'(req_data.slot) >= count_ff) begin
                        status_in = bhq_pkg::ST_RANGE;
                     end else begin
                        idx_in  = IB'(req_data.slot);
                        down_in = 1'b1;
                        if (req_data.operation == bhq_pkg::OP_REPLACE) begin
                           state_in = bhq_pkg::S_UP_RD;
                        end else begin
                           count_in = count_ff - CNT_ONE;
                           // Deleting the last entry needs no repair.
                           if (CB'(req_data.slot) != count_ff - CNT_ONE) begin
                              state_in = bhq_pkg::S_LAST_RD;
                           end
                        end
                     end
                  end
               endcase
            end
         end
         bhq_pkg::S_ROOT_RD: begin
            rd_en    = 1'b1;
            rd_addr  = '0;
            state_in = bhq_pkg::S_LAST_RD;
         end
         bhq_pkg::S_LAST_RD: begin
            if (op_ff == bhq_pkg::OP_EXTRACT) begin
               key_out_in = rd_key;
            end
            rd_en    = 1'b1;
            rd_addr  = count_ff[IB-1:0];
            state_in = bhq_pkg::S_LAST_CAP;
         end
         bhq_pkg::S_LAST_CAP: begin
            key_in = rd_key;
            if (op_ff == bhq_pkg::OP_EXTRACT) begin
               state_in = bhq_pkg::S_DN_RDL;
            end else begin
               state_in = bhq_pkg::S_UP_RD;
            end
         end
         bhq_pkg::S_UP_RD: begin
            if (idx_ff == '0) begin
               if (moved_ff || !down_ff) begin
                  wr_en    = 1'b1;
                  state_in = bhq_pkg::S_DONE;
               end else begin
                  state_in = bhq_pkg::S_DN_RDL;
               end
            end else begin
               rd_en    = 1'b1;
               rd_addr  = parent_idx;
               state_in = bhq_pkg::S_UP_CMP;
            end
         end
         bhq_pkg::S_UP_CMP: begin
            if (key_ff < rd_key) begin
               wr_en    = 1'b1;
               wr_data  = rd_raw;
               idx_in   = parent_idx;
               moved_in = 1'b1;
               state_in = bhq_pkg::S_UP_RD;
            end else if (moved_ff || !down_ff) begin
               wr_en    = 1'b1;
               state_in = bhq_pkg::S_DONE;
            end else begin
               // A key that did not rise may still have to sink.
               state_in = bhq_pkg::S_DN_RDL;
            end
         end
         bhq_pkg::S_DN_RDL: begin
            if (CB'(left_idx) >= count_ff) begin
               wr_en    = 1'b1;
               state_in = bhq_pkg::S_DONE;
            end else begin
               rd_en    = 1'b1;
               rd_addr  = left_idx[IB-1:0];
               state_in = bhq_pkg::S_DN_RDR;
            end
         end
         bhq_pkg::S_DN_RDR: begin
            if (rd_key < key_ff) begin
               best_in      = rd_key;
               best_left_in = 1'b1;
            end else begin
               best_in      = key_ff;
               best_left_in = 1'b0;
            end
            have_r_in = (CB'(right_idx) < count_ff);
            rd_en     = 1'b1;
            rd_addr   = right_idx[IB-1:0];
            state_in  = bhq_pkg::S_DN_CMP;
         end
         bhq_pkg::S_DN_CMP: begin
            if (have_r_ff && (rd_key < best_ff)) begin
               wr_en    = 1'b1;
               wr_data  = rd_raw;
               idx_in   = right_idx[IB-1:0];
               state_in = bhq_pkg::S_DN_RDL;
            end else if (best_left_ff) begin
               wr_en    = 1'b1;
               wr_data  = best_ff;
               idx_in   = left_idx[IB-1:0];
               state_in = bhq_pkg::S_DN_RDL;
            end else begin
               wr_en    = 1'b1;
               state_in = bhq_pkg::S_DONE;
            end
         end
         bhq_pkg::S_DONE: begin
            if (rsp_free) begin
               rsp_in.key_out = key_out_ff;
               rsp_in.status  = status_ff;
               rsp_in.count   = count_ff;
               rsp_valid_in   = 1'b1;
               state_in       = bhq_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = bhq_pkg::S_IDLE;
         end
      endcase
   end

endmodule

// ===== tb/binary_min_heap_priority_queue_tb.sv =====
// Testbench for binary_min_heap_priority_queue. It sends heap operations as request words
// and checks every response word against a behavioral min-heap kept in this file.
// Depends on bhq_pkg and the binary_min_heap_priority_queue RTL.
module binary_min_heap_priority_queue_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import bhq_pkg::*;

   localparam int GAP_MAX     = 18;
   localparam int TAIL_CYCLES = 60;
   localparam int LONG_HOLD   = 400;

   logic    clock = 1'b0;
   logic    reset;
   logic    req_valid;
   logic    req_ready;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_ready;
   rsp_type rsp_data;

   // Behavioral copy of the heap, updated when each request word is accepted.
   logic signed [KEY_BITS-1:0] heap_keys [CAPACITY];
   int      heap_count = 0;
   rsp_type expected_rsps [$];
   int      mismatch_count = 0;
   bit      idle_on = 1'b1;
   int      rsp_hold_cycles = 0;

   binary_min_heap_priority_queue u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   always #5 clock = ~clock;

   function automatic void swap_keys(int a, int b);
      logic signed [KEY_BITS-1:0] held;
      held         = heap_keys[a];
      heap_keys[a] = heap_keys[b];
      heap_keys[b] = held;
   endfunction

   function automatic void float_up(int i);
      int parent;
      while (i != 0) begin
         parent = (i - 1) / 2;
         if (heap_keys[i] >= heap_keys[parent]) break;
         swap_keys(i, parent);
         i = parent;
      end
   endfunction

   function automatic void sink_down(int i);
      int least;
      int left;
      int right;
      forever begin
         least = i;
         left  = 2 * i + 1;
         right = 2 * i + 2;
         if (left < heap_count && heap_keys[left] < heap_keys[least]) least = left;
         if (right < heap_count && heap_keys[right] < heap_keys[least]) least = right;
         if (least == i) break;
         swap_keys(i, least);
         i = least;
      end
   endfunction

   // Applies one operation to the behavioral heap and returns the response it must give.
   function automatic rsp_type predict_heap_op(req_type w);
      rsp_type r;
      int      pos;
      r        = '0;
      r.status = ST_OK;
      pos      = w.slot;
      case (op_type'(w.operation))
         OP_INSERT: begin
            if (heap_count >= CAPACITY) begin
               r.status = ST_FULL;
            end else begin
               heap_keys[heap_count] = w.key_in;
               heap_count++;
               float_up(heap_count - 1);
            end
         end
         OP_EXTRACT: begin
            if (heap_count == 0) begin
               r.status = ST_EMPTY;
            end else begin
               r.key_out    = heap_keys[0];
               heap_count--;
               heap_keys[0] = heap_keys[heap_count];
               sink_down(0);
            end
         end
         OP_REPLACE: begin
            if (pos >= heap_count) begin
               r.status = ST_RANGE;
            end else begin
               heap_keys[pos] = w.key_in;
               float_up(pos);
               sink_down(pos);
            end
         end
         default: begin
            if (pos >= heap_count) begin
               r.status = ST_RANGE;
            end else begin
               heap_count--;
               heap_keys[pos] = heap_keys[heap_count];
               if (pos < heap_count) begin
                  float_up(pos);
                  sink_down(pos);
               end
            end
         end
      endcase
      r.count = heap_count[CNT_BITS-1:0];
      return r;
   endfunction

   function automatic logic signed [KEY_BITS-1:0] pick_key();
      case ($urandom_range(0, 4))
         0: return $urandom_range(0, 1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
         1: return $signed($urandom_range(0, 16)) - 8;
         2: return 32'sh8000_0000 + $urandom_range(0, 15);
         default: return $urandom;
      endcase
   endfunction

   // Called at a rising edge; returns at the edge where the word is accepted.
   task automatic send_word(op_type op, logic signed [KEY_BITS-1:0] key, int slot);
      req_type w;
      rsp_type want;
      int      gap;
      w.operation = op;
      w.key_in    = key;
      w.slot      = SLOT_BITS'(slot);
      gap         = idle_on ? $urandom_range(0, GAP_MAX) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= w;
      do @(posedge clock); while (!req_ready);
      want          = predict_heap_op(w);
      expected_rsps = {expected_rsps, want};
   endtask

   task automatic drain_words();
      req_valid <= 1'b0;
      while (expected_rsps.size() != 0) @(posedge clock);
   endtask

   task automatic test_directed_cases();
      idle_on = 1'b0;
      send_word(OP_EXTRACT, 32'sd5, 0);
      send_word(OP_REPLACE, 32'sd1, 0);
      send_word(OP_DELETE, '0, 0);
      send_word(OP_INSERT, 32'sh7FFF_FFFF, 0);
      send_word(OP_INSERT, 32'sd0, 5);
      send_word(OP_INSERT, -32'sd1, 0);
      send_word(OP_INSERT, 32'sh8000_0000, 0);
      send_word(OP_INSERT, 32'sd7, 0);
      send_word(OP_INSERT, 32'sd7, 0);
      // The root takes the largest key and has to sink to a leaf.
      send_word(OP_REPLACE, 32'sh7FFF_FFFF, 0);
      // The last entry takes the smallest key and has to climb to the root.
      send_word(OP_REPLACE, 32'sh8000_0000, heap_count - 1);
      send_word(OP_REPLACE, 32'sd3, heap_count);
      send_word(OP_DELETE, '0, 127);
      send_word(OP_DELETE, '0, 1);
      send_word(OP_DELETE, '0, heap_count - 1);
      send_word(OP_DELETE, '0, 0);
      while (heap_count > 0) send_word(OP_EXTRACT, -32'sd1, 127);
      send_word(OP_EXTRACT, '0, 0);
      drain_words();
   endtask

   task automatic test_fill_and_empty();
      idle_on = 1'b1;
      while (heap_count < CAPACITY) send_word(OP_INSERT, pick_key(), $urandom_range(0, 127));
      send_word(OP_INSERT, pick_key(), 0);
      send_word(OP_REPLACE, 32'sh8000_0000, CAPACITY - 1);
      send_word(OP_REPLACE, 32'sh7FFF_FFFF, 0);
      send_word(OP_DELETE, '0, CAPACITY - 1);
      send_word(OP_DELETE, '0, CAPACITY - 1);
      send_word(OP_INSERT, 32'sh7FFF_FFFF, 0);
      send_word(OP_INSERT, pick_key(), 0);
      // Emptying a full heap checks that minimums come out in sorted order.
      while (heap_count > 0) send_word(OP_EXTRACT, pick_key(), $urandom_range(0, 127));
      drain_words();
   endtask

   task automatic test_output_backpressure();
      idle_on         = 1'b0;
      rsp_hold_cycles = LONG_HOLD;
      repeat (16) send_word(OP_INSERT, pick_key(), 0);
      repeat (8) send_word(OP_EXTRACT, '0, 0);
      drain_words();
   endtask

   task automatic test_random_mix(int n_words, int insert_pct);
      int     slot;
      op_type op;
      for (int k = 0; k < n_words; k++) begin
         if (k % 64 == 0) idle_on = ($urandom_range(0, 3) != 0);
         if ($urandom_range(0, 99) < insert_pct) begin
            op = OP_INSERT;
         end else begin
            case ($urandom_range(0, 2))
               0: op = OP_EXTRACT;
               1: op = OP_REPLACE;
               default: op = OP_DELETE;
            endcase
         end
         if (heap_count > 0 && $urandom_range(0, 9) < 8) slot = $urandom_range(0, heap_count - 1);
         else slot = $urandom_range(0, 127);
         send_word(op, pick_key(), slot);
      end
      drain_words();
   endtask

   // When idle gaps are on, the receiver stalls a random number of cycles before each word,
   // or once for a long stretch when a test asks for it.
   initial begin : receiver
      int stall;
      rsp_ready <= 1'b0;
      do @(posedge clock); while (reset);
      forever begin
         if (rsp_hold_cycles > 0) begin
            stall           = rsp_hold_cycles;
            rsp_hold_cycles = 0;
         end else begin
            stall = idle_on ? $urandom_range(0, GAP_MAX) : 0;
         end
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
      end
   end

   always @(posedge clock) begin : check_rsp
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_rsps.size() == 0) begin
            $error("unexpected response word: key_out %0d status %0d count %0d",
                   rsp_data.key_out, rsp_data.status, rsp_data.count);
            mismatch_count++;
         end else begin
            want = expected_rsps.pop_front();
            if (rsp_data.key_out !== want.key_out) begin
               $error("key_out: expected %0d, actual %0d", want.key_out, rsp_data.key_out);
               mismatch_count++;
            end
            if (rsp_data.status !== want.status) begin
               $error("status: expected %0d, actual %0d", want.status, rsp_data.status);
               mismatch_count++;
            end
            if (rsp_data.count !== want.count) begin
               $error("count: expected %0d, actual %0d", want.count, rsp_data.count);
               mismatch_count++;
            end
         end
      end
   end

   initial begin : stimulus
      reset     <= 1'b1;
      req_valid <= 1'b0;
      req_data  <= '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      test_directed_cases();
      test_fill_and_empty();
      test_output_backpressure();
      test_random_mix(330, 60);
      test_random_mix(330, 25);
      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

   initial begin : watchdog
      #10ms;
      $display("FAILURE");
      $finish;
   end

endmodule

// ===== filelist.f =====
rtl/bhq_pkg.sv
rtl/bhq_ram.sv
rtl/binary_min_heap_priority_queue.sv
tb/binary_min_heap_priority_queue_tb.sv
